// ===== sv/pid_controller_antiwindup_assert.svh =====
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion wrappers. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge, suspended while reset is high
`define PIDAW_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every clock edge, including reset
`define PIDAW_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIDAW_ASSERT(name, clk, rst, prop, msg)
`define PIDAW_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== sv/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Payload types, configuration and state records, codes and the limit clamp.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   // Data word: signed fixed point
   localparam int DATA_W = 32;
   // Exact width of the widest sum: two products plus the integral
   localparam int SUM_W = 2 * DATA_W + 3;

   // Command codes
   localparam logic [1:0] CMD_STEP    = 2'd0;
   localparam logic [1:0] CMD_ENABLE  = 2'd1;
   localparam logic [1:0] CMD_DISABLE = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_STEP     = 2'd0;
   localparam logic [1:0] STATUS_DISABLED = 2'd1;
   localparam logic [1:0] STATUS_COMMAND  = 2'd2;

   // Register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_I     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_HIGH = 3'd5;

   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      logic [1:0]               cmd;
      logic signed [DATA_W-1:0] measurement;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
      logic signed [DATA_W-1:0] target;
      logic signed [DATA_W-1:0] limit_low;
      logic signed [DATA_W-1:0] limit_high;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] integral_sum;
      logic signed [DATA_W-1:0] previous_measurement;
      logic signed [DATA_W-1:0] last_drive;
      logic                     running;
   } state_type;

   // Clamp to the limits; with crossed limits the lower one wins
   function automatic logic signed [DATA_W-1:0] clamp_value(
      input logic signed [SUM_W-1:0]  value,
      input logic signed [DATA_W-1:0] low,
      input logic signed [DATA_W-1:0] high
   );
      logic signed [SUM_W-1:0] t;
      t = value;
      if (t > SUM_W'(high)) t = SUM_W'(high);
      if (t < SUM_W'(low)) t = SUM_W'(low);
      return DATA_W'(t);
   endfunction

endpackage

// ===== sv/pidaw_datapath.sv =====
// ----------------------------------------------------------------------------
// PID controller datapath
// One item's arithmetic: error, three gain products, integral update with
// clamp, drive sum with clamp, and the enable/disable state changes.
// ----------------------------------------------------------------------------
module pidaw_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  pidaw_pkg::req_type   item,
   input  pidaw_pkg::cfg_type   cfg,
   input  pidaw_pkg::state_type state_cur,
   output pidaw_pkg::state_type state_next,
   output pidaw_pkg::rsp_type   result
);
   import pidaw_pkg::*;

   localparam int PROD_W = 2 * DATA_W + 1;

   // -1.0 in the output format, saturated when the fraction fills the word
   localparam logic signed [DATA_W-1:0] DriveDisabled =
      (FRAC_BITS >= DATA_W) ? DATA_MIN : -(DATA_W'(1) << FRAC_BITS);

   logic signed [DATA_W:0]    error;
   logic signed [DATA_W:0]    delta;
   logic signed [PROD_W-1:0]  prod_p;
   logic signed [PROD_W-1:0]  prod_i;
   logic signed [PROD_W-1:0]  prod_d;
   logic signed [PROD_W-1:0]  scaled_p;
   logic signed [PROD_W-1:0]  scaled_i;
   logic signed [PROD_W-1:0]  scaled_d;
   logic signed [SUM_W-1:0]   integral_raw;
   logic signed [DATA_W-1:0]  integral_new;
   logic signed [SUM_W-1:0]   drive_raw;
   logic signed [DATA_W-1:0]  drive_new;

   // Differences at one extra bit, exact
   assign error = {cfg.target[DATA_W-1], cfg.target}
                - {item.measurement[DATA_W-1], item.measurement};
   assign delta = {item.measurement[DATA_W-1], item.measurement}
                - {state_cur.previous_measurement[DATA_W-1], state_cur.previous_measurement};

   // Products, scaled back with floor rounding
   assign prod_p   = PROD_W'(cfg.gain_p) * PROD_W'(error);
   assign prod_i   = PROD_W'(cfg.gain_i) * PROD_W'(error);
   assign prod_d   = PROD_W'(cfg.gain_d) * PROD_W'(delta);
   assign scaled_p = prod_p >>> FRAC_BITS;
   assign scaled_i = prod_i >>> FRAC_BITS;
   assign scaled_d = prod_d >>> FRAC_BITS;

   // Integral with anti-windup clamp, then the drive
   assign integral_raw = SUM_W'(state_cur.integral_sum) + SUM_W'(scaled_i);
   assign integral_new = clamp_value(integral_raw, cfg.limit_low, cfg.limit_high);
   assign drive_raw    = SUM_W'(scaled_p) + SUM_W'(integral_new) - SUM_W'(scaled_d);
   assign drive_new    = clamp_value(drive_raw, cfg.limit_low, cfg.limit_high);

   // Select next state and result by command
   always_comb begin
      state_next    = state_cur;
      result.drive  = '0;
      result.status = STATUS_COMMAND;
      case (item.cmd)
         CMD_STEP: begin
            if (state_cur.running) begin
               state_next.integral_sum         = integral_new;
               state_next.last_drive           = drive_new;
               state_next.previous_measurement = item.measurement;
               result.drive                    = drive_new;
               result.status                   = STATUS_STEP;
            end else begin
               result.drive  = DriveDisabled;
               result.status = STATUS_DISABLED;
            end
         end
         CMD_ENABLE: begin
            // Seed from the held output so enabling causes no jump
            if (!state_cur.running) begin
               state_next.previous_measurement = item.measurement;
               state_next.integral_sum = clamp_value(SUM_W'(state_cur.last_drive),
                                                     cfg.limit_low, cfg.limit_high);
            end
            state_next.running = 1'b1;
         end
         CMD_DISABLE: begin
            state_next.running = 1'b0;
         end
         default: begin
            // Unused command: no state change
            state_next = state_cur;
         end
      endcase
   end

endmodule

// ===== sv/pid_controller_antiwindup.sv =====
// ----------------------------------------------------------------------------
// PID controller with anti-windup
// Signed fixed-point PID, derivative on measurement, clamped integral.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result item. An item is captured in
// an input register and then resolved by a single pass through the datapath
// (three gain multipliers, integral add and clamp, drive add and clamp) into
// the result register, so the block takes one item per cycle while the output
// side is not stalled. The multiply-add-clamp chain from the input register to
// the result register and controller state sets the clock rate. Registers must
// be written through the csr_ port only while no item is in flight; the block
// itself does not enforce this. Limit writes apply from the next step or enable.
// A step while disabled returns -1.0 with status 1 and changes nothing.
`include "pid_controller_antiwindup_assert.svh"

module pid_controller_antiwindup #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pidaw_pkg::req_type                   req_data,
   // Result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pidaw_pkg::rsp_type                   rsp_data,
   // Register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pidaw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pidaw_pkg::DATA_W-1:0]         csr_data
);
   import pidaw_pkg::*;

   req_type   in_ff;
   logic      in_valid_ff;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_in;
   logic      advance;

   // Move the held item forward when the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   pidaw_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .item       (in_ff),
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .result     (rsp_in)
   );

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= '0;
         cfg_ff.gain_i     <= '0;
         cfg_ff.gain_d     <= '0;
         cfg_ff.target     <= '0;
         cfg_ff.limit_low  <= DATA_MIN;
         cfg_ff.limit_high <= DATA_MAX;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GAIN_P:     cfg_ff.gain_p     <= csr_data;
            REG_GAIN_I:     cfg_ff.gain_i     <= csr_data;
            REG_GAIN_D:     cfg_ff.gain_d     <= csr_data;
            REG_TARGET:     cfg_ff.target     <= csr_data;
            REG_LIMIT_LOW:  cfg_ff.limit_low  <= csr_data;
            REG_LIMIT_HIGH: cfg_ff.limit_high <= csr_data;
            default: begin
               // Index beyond the register list: drop the write
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Input register: hold the item until it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // Result register and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Checks
   `PIDAW_ASSERT(a_held_item_kept, clock, reset, in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff), "held item lost or changed")
   `PIDAW_ASSERT(a_disabled_step_no_change, clock, reset, advance && !state_ff.running && in_ff.cmd == CMD_STEP |=> $stable(state_ff) && rsp_ff.status == STATUS_DISABLED, "step while disabled changed state")
   `PIDAW_ASSERT(a_step_drive_matches, clock, reset, advance && state_ff.running && in_ff.cmd == CMD_STEP |=> rsp_valid_ff && rsp_ff.status == STATUS_STEP && rsp_ff.drive == state_ff.last_drive, "step result differs from stored drive")
   `PIDAW_ASSERT(a_disable_stops, clock, reset, advance && in_ff.cmd == CMD_DISABLE |=> !state_ff.running && rsp_ff.status == STATUS_COMMAND, "disable did not stop the controller")
   `PIDAW_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_valid_ff && !in_valid_ff && !state_ff.running, "reset did not clear control state")

endmodule

// ===== tb/sv/pidaw_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller result checker
// Watches the register, input and result channels, keeps its own copy of the
// controller state and registers, predicts the result of every accepted item
// and compares each returned result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module pidaw_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  pidaw_pkg::req_type                   req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  pidaw_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [pidaw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pidaw_pkg::DATA_W-1:0]         csr_data,
   output int                                   failures,
   output int                                   pending,
   output int                                   checked
);
   import pidaw_pkg::*;

   typedef logic signed [63:0] wide_type;

   localparam wide_type WIDE_MIN = {1'b1, {63{1'b0}}};
   localparam wide_type WIDE_MAX = {1'b0, {63{1'b1}}};

   // Register copy and controller state as seen from outside
   logic signed [DATA_W-1:0] csr_copy [0:5];
   wide_type integral_acc;
   wide_type last_measurement;
   wide_type held_drive;
   logic     enabled;

   rsp_type expected_drives [$];
   rsp_type due;
   int      fail_count = 0;
   int      checked_count = 0;

   // Saturating 64-bit sum and difference
   function automatic wide_type sat_sum(input wide_type a, input wide_type b);
      logic signed [64:0] s;
      s = a + b;
      if (s[64] != s[63]) return s[64] ? WIDE_MIN : WIDE_MAX;
      return s[63:0];
   endfunction

   function automatic wide_type sat_diff(input wide_type a, input wide_type b);
      logic signed [64:0] s;
      s = a - b;
      if (s[64] != s[63]) return s[64] ? WIDE_MIN : WIDE_MAX;
      return s[63:0];
   endfunction

   // Exact product, floor shift by the fraction bits, saturate to 64 bits
   function automatic wide_type scaled_product(input wide_type a, input wide_type b);
      logic signed [127:0] p;
      p = a * b;
      p = p >>> FRAC_BITS;
      if (p[127:63] != {65{p[127]}}) return p[127] ? WIDE_MIN : WIDE_MAX;
      return p[63:0];
   endfunction

   // High limit first, then low, so crossed limits leave the low one
   function automatic wide_type clamp_to_limits(input wide_type v);
      wide_type lo, hi;
      lo = csr_copy[REG_LIMIT_LOW];
      hi = csr_copy[REG_LIMIT_HIGH];
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   // Advance the controller state by one item and return its result
   function automatic rsp_type control_response(input req_type item);
      rsp_type  r;
      wide_type meas, err, delta, acc, floor_word;
      meas     = item.measurement;
      r.drive  = '0;
      r.status = STATUS_COMMAND;
      case (item.cmd)
         CMD_STEP: begin
            if (!enabled) begin
               floor_word = DATA_MIN;
               acc = -(64'sd1 <<< FRAC_BITS);
               if (acc < floor_word) acc = floor_word;
               r.drive  = acc[DATA_W-1:0];
               r.status = STATUS_DISABLED;
            end else begin
               err   = sat_diff(csr_copy[REG_TARGET], meas);
               delta = sat_diff(meas, last_measurement);
               integral_acc = clamp_to_limits(
                  sat_sum(integral_acc, scaled_product(csr_copy[REG_GAIN_I], err)));
               acc = sat_sum(scaled_product(csr_copy[REG_GAIN_P], err), integral_acc);
               acc = sat_diff(acc, scaled_product(csr_copy[REG_GAIN_D], delta));
               held_drive       = clamp_to_limits(acc);
               last_measurement = meas;
               r.drive  = held_drive[DATA_W-1:0];
               r.status = STATUS_STEP;
            end
         end
         CMD_ENABLE: begin
            // seed from the held drive so that enabling causes no jump
            if (!enabled) begin
               last_measurement = meas;
               integral_acc     = clamp_to_limits(held_drive);
            end
            enabled = 1'b1;
         end
         CMD_DISABLE: enabled = 1'b0;
         default: ;
      endcase
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic clear_model();
      csr_copy[REG_GAIN_P]     = '0;
      csr_copy[REG_GAIN_I]     = '0;
      csr_copy[REG_GAIN_D]     = '0;
      csr_copy[REG_TARGET]     = '0;
      csr_copy[REG_LIMIT_LOW]  = DATA_MIN;
      csr_copy[REG_LIMIT_HIGH] = DATA_MAX;
      integral_acc     = '0;
      last_measurement = '0;
      held_drive       = '0;
      enabled          = 1'b0;
      expected_drives.delete();
   endtask

   // Track writes, predict accepted items, compare returned results
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_valid && csr_ready && csr_index <= REG_LIMIT_HIGH)
            csr_copy[csr_index] = csr_data;
         if (req_valid && req_ready)
            expected_drives.push_back(control_response(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               note_mismatch($sformatf("result with nothing due: drive %0d status %0d",
                                       rsp_data.drive, rsp_data.status));
            end else begin
               due = expected_drives.pop_front();
               checked_count++;
               if (rsp_data.drive !== due.drive)
                  note_mismatch($sformatf("drive %0d, expected %0d",
                                          rsp_data.drive, due.drive));
               if (rsp_data.status !== due.status)
                  note_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_data.status, due.status));
            end
         end
      end
      failures <= fail_count;
      pending  <= expected_drives.size();
      checked  <= checked_count;
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Resets the controller, runs a short directed sequence over the corner cases
// (disabled steps, spare command code, saturating gains and measurements,
// crossed limits, re-enable), then random phases under random register
// settings, with bursty input traffic and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;
   import pidaw_pkg::*;

   localparam int FRAC_BITS       = 16;
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int LIMIT_CYCLES    = 200000;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 100;

   // Command code the block does not use, and an index with no register
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NONE = 3'd7;
   localparam logic signed [DATA_W-1:0] ONE = 1 << FRAC_BITS;

   typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_TOGGLE, RX_HOLD} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   req_type req_data;
   logic rsp_valid, rsp_ready;
   rsp_type rsp_data;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_data;
   logic hold_request;

   int failures, pending, checked;
   int cycle_count = 0;
   int burst_left = 0;
   int cmd_seen [4] = '{0, 0, 0, 0};
   int csr_writes = 0;
   int settings_seen = 0;
   bit running_now = 1'b0;
   logic signed [DATA_W-1:0] target_now = '0;

   pid_controller_antiwindup #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   pidaw_checker #(.FRAC_BITS(FRAC_BITS)) pid_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .pending(pending), .checked(checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("pid_controller_antiwindup test failed");
         $finish;
      end
   end

   // Result side: stall in random segments, one long hold when asked
   initial begin
      rx_mode_type mode;
      int span;
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(1, 40);
         if (hold_request === 1'b1 && !held) begin
            held = 1'b1;
            mode = RX_HOLD;
            span = HOLD_CYCLES;
         end
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            case (mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               RX_TOGGLE: rsp_ready <= k[0];
               default:   rsp_ready <= 1'b0;
            endcase
         end
      end
   end

   // Offer one item and hold it until taken; idle between bursts
   task automatic send_item(input logic [1:0] cmd, input logic signed [DATA_W-1:0] meas);
      req_type item;
      item.cmd         = cmd;
      item.measurement = meas;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      cmd_seen[cmd]++;
      if (cmd == CMD_ENABLE) running_now = 1'b1;
      else if (cmd == CMD_DISABLE) running_now = 1'b0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Drop the input, wait for every due result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leave valid high; the caller drops it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
   endtask

   task automatic load_settings(input logic signed [DATA_W-1:0] gp, gi, gd, tgt, lo, hi);
      drain();
      write_reg(REG_GAIN_P, gp);
      write_reg(REG_GAIN_I, gi);
      write_reg(REG_GAIN_D, gd);
      write_reg(REG_TARGET, tgt);
      write_reg(REG_LIMIT_LOW, lo);
      write_reg(REG_LIMIT_HIGH, hi);
      csr_valid <= 1'b0;
      settings_seen++;
      target_now = tgt;
   endtask

   function automatic logic signed [DATA_W-1:0] random_gain();
      case ($urandom_range(0, 5))
         0: return DATA_MAX;
         1: return DATA_MIN;
         2: return $urandom;
         default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   // Mostly near the setpoint, sometimes anywhere, sometimes at the rails
   function automatic logic signed [DATA_W-1:0] pick_measurement();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
         default: return target_now + ($signed($urandom_range(0, 32'h0004_0000))
                                       - 32'sh0002_0000);
      endcase
   endfunction

   initial begin
      int roll;
      logic signed [DATA_W-1:0] gp, gi, gd, tgt, lo, hi, a, b;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      hold_request <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: disabled step, spare code, disable, enable twice, zero gains
      send_item(CMD_STEP, '0);
      send_item(CMD_SPARE, DATA_MAX);
      send_item(CMD_DISABLE, DATA_MIN);
      send_item(CMD_ENABLE, DATA_MIN);
      send_item(CMD_ENABLE, DATA_MAX);
      send_item(CMD_STEP, DATA_MAX);

      // Extreme gains and setpoint under the widest limits
      load_settings(DATA_MAX, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX);
      send_item(CMD_STEP, DATA_MAX);
      send_item(CMD_STEP, DATA_MIN);
      send_item(CMD_STEP, '0);
      send_item(CMD_STEP, -1);
      send_item(CMD_STEP, ONE);

      // Crossed limits, then disable and re-enable under them
      load_settings(ONE, ONE >>> 2, 2 * ONE, 3 * ONE, ONE, -ONE);
      write_reg(REG_NONE, '1);
      csr_valid <= 1'b0;
      send_item(CMD_STEP, '0);
      send_item(CMD_STEP, DATA_MAX);
      send_item(CMD_DISABLE, '0);
      send_item(CMD_STEP, 5);
      send_item(CMD_ENABLE, ONE);
      send_item(CMD_STEP, ONE);

      load_settings(DATA_MIN, DATA_MAX, DATA_MAX, DATA_MAX, -ONE, ONE);
      send_item(CMD_STEP, DATA_MIN);
      send_item(CMD_STEP, DATA_MAX);

      // Random phases, each under fresh settings and starting enabled
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         gp = random_gain();
         gi = random_gain();
         gd = random_gain();
         if ($urandom_range(0, 3) == 0) tgt = $urandom;
         else tgt = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         case ($urandom_range(0, 5))
            0: begin
               lo = DATA_MIN;
               hi = DATA_MAX;
            end
            1: begin
               a  = $urandom_range(0, 32'h0100_0000);
               lo = a;
               hi = -a;
            end
            default: begin
               a = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
               b = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
               lo = (a <= b) ? a : b;
               hi = (a <= b) ? b : a;
            end
         endcase
         load_settings(gp, gi, gd, tgt, lo, hi);
         // hold the result side off while input keeps coming
         if (phase == 2) hold_request <= 1'b1;
         send_item(CMD_ENABLE, pick_measurement());
         for (int k = 1; k < ITEMS_PER_PHASE; k++) begin
            roll = $urandom_range(0, 99);
            if (!running_now && roll < 60) send_item(CMD_ENABLE, pick_measurement());
            else if (roll < 88) send_item(CMD_STEP, pick_measurement());
            else if (roll < 93) send_item(CMD_ENABLE, pick_measurement());
            else if (roll < 97) send_item(CMD_DISABLE, pick_measurement());
            else send_item(CMD_SPARE, $urandom);
         end
      end

      drain();
      $display("covered %0d items: %0d steps, %0d enables, %0d disables, %0d spare codes",
               cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
               cmd_seen[CMD_STEP], cmd_seen[CMD_ENABLE], cmd_seen[CMD_DISABLE],
               cmd_seen[CMD_SPARE]);
      $display("%0d results checked under %0d register settings (%0d writes)",
               checked, settings_seen, csr_writes);
      if (failures == 0 && pending == 0) begin
         $display("pid_controller_antiwindup test passed");
      end else begin
         $display("pid_controller_antiwindup test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pidaw_pkg.sv
sv/pidaw_datapath.sv
sv/pid_controller_antiwindup.sv
tb/sv/pidaw_checker.sv
tb/sv/testbench.sv
